FILE: rtl/core/assert_macros.svh
// Assertion macros used by the handle allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define GHA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define GHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/gha_pkg.sv
// Types, codes and constants of the generational handle allocator.
package gha_pkg;

	localparam int MaxSlots = 1024;
	localparam int SlotW    = $clog2(MaxSlots);
	localparam int CntW     = SlotW + 1;
	localparam int GenW     = 32;
	localparam int RowW     = 32;

	typedef enum logic [1:0] {
		OP_CREATE_REUSE = 2'd0,
		OP_CREATE_FRESH = 2'd1,
		OP_KILL         = 2'd2,
		OP_LOOKUP       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		op_t             op;
		logic [9:0]      slot_index;
		logic [31:0]     row_value;
	} req_beat_t;

	typedef struct packed {
		logic [9:0]      handle_id;
		logic [31:0]     handle_generation;
		status_t         status;
	} rsp_beat_t;

	// One slot record: live mark, generation, row or next-free link.
	typedef struct packed {
		logic            live;
		logic [GenW-1:0] gen;
		logic [RowW-1:0] link;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_room;
	} ctl_sts_t;

endpackage

FILE: rtl/core/gha_ram.sv
// Generic simple dual-port RAM with registered read data.
module gha_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/gha_ctrl.sv
// Controller state machine: takes a request beat, then commits it.
module gha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  gha_pkg::ctl_sts_t sts,
	output gha_pkg::ctl_cmd_t cmd
);

	gha_pkg::state_t state_q;
	gha_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gha_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gha_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = gha_pkg::S_EXEC;
				end
			end
			gha_pkg::S_EXEC: begin
				if (sts.out_room) begin
					state_d = gha_pkg::S_IDLE;
				end
			end
			default: state_d = gha_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			gha_pkg::S_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			gha_pkg::S_EXEC: begin
				cmd.commit = sts.out_room;
			end
			default: req_stall = 1'b1;
		endcase
	end

endmodule

FILE: rtl/core/gha_datapath.sv
// Datapath: slot record RAM, free-list head, slot count and result register.
`include "assert_macros.svh"

module gha_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  gha_pkg::req_beat_t req,
	input  gha_pkg::ctl_cmd_t  cmd,
	output gha_pkg::ctl_sts_t  sts,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output gha_pkg::rsp_beat_t rsp
);

	localparam int SlotW = gha_pkg::SlotW;
	localparam int CntW  = gha_pkg::CntW;
	localparam int GenW  = gha_pkg::GenW;
	localparam int RowW  = gha_pkg::RowW;
	localparam logic [CntW-1:0] MaxCnt = CntW'(gha_pkg::MaxSlots);

	gha_pkg::op_t       op_q;
	logic [SlotW-1:0]   slot_q;
	logic [RowW-1:0]    row_q;
	logic [CntW-1:0]    free_head_q;
	logic [CntW-1:0]    slots_used_q;
	logic               rsp_valid_q;
	gha_pkg::rsp_beat_t rsp_q;

	gha_pkg::entry_t    rd_entry;
	gha_pkg::entry_t    wr_entry;
	logic [SlotW-1:0]   raddr;
	logic [SlotW-1:0]   waddr;
	logic               we;
	logic [GenW-1:0]    gen_inc;

	logic               reuse_hit;
	logic               append;
	logic               full;
	logic               slot_live;
	logic               kill_ok;
	logic               look_ok;
	gha_pkg::rsp_beat_t res;

	assign raddr = (req.op == gha_pkg::OP_CREATE_REUSE) ? free_head_q[SlotW-1:0]
		: req.slot_index;

	gha_ram #(
		.Width($bits(gha_pkg::entry_t)),
		.Depth(gha_pkg::MaxSlots)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_entry),
		.re   (cmd.capture),
		.raddr(raddr),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= req.op;
			slot_q <= req.slot_index;
			row_q  <= req.row_value;
		end
	end

	assign gen_inc   = rd_entry.gen + GenW'(1);
	assign reuse_hit = (op_q == gha_pkg::OP_CREATE_REUSE) && (free_head_q < MaxCnt);
	assign append    = ((op_q == gha_pkg::OP_CREATE_REUSE) && !reuse_hit)
		|| (op_q == gha_pkg::OP_CREATE_FRESH);
	assign full      = append && (slots_used_q >= MaxCnt);
	assign slot_live = ({1'b0, slot_q} < slots_used_q) && rd_entry.live;
	assign kill_ok   = (op_q == gha_pkg::OP_KILL) && slot_live;
	assign look_ok   = (op_q == gha_pkg::OP_LOOKUP) && slot_live && (slot_q != '0);

	assign we = cmd.commit && (reuse_hit || (append && !full) || kill_ok);

	always_comb begin
		waddr    = slot_q;
		wr_entry = '{live: 1'b0, gen: gen_inc, link: RowW'(free_head_q)};
		res      = '{handle_id: '0, handle_generation: '0, status: gha_pkg::ST_INVALID};
		if (reuse_hit) begin
			waddr    = free_head_q[SlotW-1:0];
			wr_entry = '{live: 1'b1, gen: rd_entry.gen, link: row_q};
			res      = '{handle_id: free_head_q[SlotW-1:0],
				handle_generation: rd_entry.gen, status: gha_pkg::ST_OK};
		end else if (append) begin
			waddr    = slots_used_q[SlotW-1:0];
			wr_entry = '{live: 1'b1, gen: '0, link: row_q};
			if (full) begin
				res.status = gha_pkg::ST_FULL;
			end else begin
				res = '{handle_id: slots_used_q[SlotW-1:0],
					handle_generation: '0, status: gha_pkg::ST_OK};
			end
		end else if (kill_ok) begin
			res = '{handle_id: slot_q, handle_generation: gen_inc, status: gha_pkg::ST_OK};
		end else if (look_ok) begin
			res = '{handle_id: slot_q, handle_generation: rd_entry.gen,
				status: gha_pkg::ST_OK};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= MaxCnt;
			slots_used_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
				if (reuse_hit) begin
					free_head_q <= rd_entry.link[CntW-1:0];
				end else if (kill_ok) begin
					free_head_q <= {1'b0, slot_q};
				end
				if (append && !full) begin
					slots_used_q <= slots_used_q + CntW'(1);
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= res;
		end
	end

	assign sts.out_room = !rsp_valid_q || !rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

	`GHA_ASSERT(a_used_bound, slots_used_q <= MaxCnt, "slot count past capacity")
	`GHA_ASSERT(a_head_bound, free_head_q <= MaxCnt, "free-list head out of range")
	`GHA_ASSERT_NXT(a_head_hold, !cmd.commit, $stable(free_head_q), "head moved without commit")
	`GHA_ASSERT_NXT(a_used_grow, 1'b1, slots_used_q >= $past(slots_used_q),
		"slot count went down")
	`GHA_ASSERT_IMP(a_commit_room, cmd.commit, sts.out_room, "commit over a held result")

endmodule

FILE: rtl/core/generational_handle_allocator_unit.sv
// Top level of the generational handle allocator.
//
//  channel | handshake            | beat type
//  --------+----------------------+--------------------
//  req     | req_valid/req_stall  | gha_pkg::req_beat_t
//  rsp     | rsp_valid/rsp_stall  | gha_pkg::rsp_beat_t
//
// Each request does one synchronous read of the slot record RAM, then, once the
// output has room, the write-back with the result loaded into the output register.
// A new request is taken only once the previous one has committed.
// Reset sets the free list empty and the slot count to zero; the RAM is not cleared.
// A stalled result holds; the request side stalls until it can be committed.
module generational_handle_allocator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  gha_pkg::req_beat_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output gha_pkg::rsp_beat_t rsp
);

	gha_pkg::ctl_cmd_t cmd;
	gha_pkg::ctl_sts_t sts;

	gha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	gha_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
